>>> rtl/lct_pkg.sv
`timescale 1ns / 1ps

package lct_pkg;

	// fixed field widths
	localparam int ACT_W  = 2;
	localparam int MAC_W  = 48;
	localparam int SEQ_W  = 22;
	localparam int PIDX_W = 4;
	localparam int CRED_W = 5;
	localparam int STAT_W = 2;

	// parameter defaults
	localparam int ENTRIES_DEF  = 16;
	localparam int SEQ_BITS_DEF = 22;

	localparam logic [CRED_W-1:0] CREDIT_RESET = 5'd10;

	// action codes
	localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_OPEN    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RESPOND = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BADSEQ   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic scan_rd;
		logic idx_rd;
		logic commit;
		logic load_out;
	} lct_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_scan;
		logic is_err;
		logic scan_last;
	} lct_sts_t;

endpackage

>>> rtl/lct_ifs.sv
`timescale 1ns / 1ps

// request channel
interface lct_req_if
	import lct_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [MAC_W-1:0]  mac_addr;
	logic [SEQ_W-1:0]  seq_num;
	logic [PIDX_W-1:0] conn_index;

	modport source (output valid, action, mac_addr, seq_num, conn_index, input ready);
	modport sink (input valid, action, mac_addr, seq_num, conn_index, output ready);
endinterface

// response channel
interface lct_rsp_if
	import lct_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [PIDX_W-1:0] entry_index;
	logic [SEQ_W-1:0]  send_seq;
	logic [CRED_W-1:0] credit_out;
	logic [SEQ_W-1:0]  ack_seq;

	modport source (output valid, status, entry_index, send_seq, credit_out, ack_seq,
		input ready);
	modport sink (input valid, status, entry_index, send_seq, credit_out, ack_seq,
		output ready);
endinterface

>>> rtl/lct_ctrl.sv
`timescale 1ns / 1ps

module lct_ctrl
	import lct_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  lct_sts_t sts,
	output lct_cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_SCAN     = 3'd2;
	localparam logic [2:0] S_SCAN_END = 3'd3;
	localparam logic [2:0] S_READ     = 3'd4;
	localparam logic [2:0] S_COMMIT   = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.load_in  = in_valid && (state_q == S_IDLE);
		cmd.scan_rd  = (state_q == S_SCAN);
		cmd.idx_rd   = (state_q == S_READ);
		cmd.commit   = (state_q == S_COMMIT);
		cmd.load_out = (state_q == S_DONE) && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.is_err)
					state_d = S_COMMIT;
				else if (sts.is_scan)
					state_d = S_SCAN;
				else
					state_d = S_READ;
			end
			S_SCAN: begin
				if (sts.scan_last)
					state_d = S_SCAN_END;
			end
			S_SCAN_END: state_d = S_COMMIT;
			S_READ:     state_d = S_COMMIT;
			S_COMMIT:   state_d = S_DONE;
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// state and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/lct_dp.sv
`timescale 1ns / 1ps

module lct_dp
	import lct_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int SEQ_BITS = SEQ_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CRED_W-1:0] cfg_wr_data,
	input  logic [ACT_W-1:0]  action,
	input  logic [MAC_W-1:0]  mac_addr,
	input  logic [SEQ_W-1:0]  seq_num,
	input  logic [PIDX_W-1:0] conn_index,
	input  lct_cmd_t          cmd,
	output lct_sts_t          sts,
	output logic [STAT_W-1:0] status,
	output logic [PIDX_W-1:0] entry_index,
	output logic [SEQ_W-1:0]  send_seq,
	output logic [CRED_W-1:0] credit_out,
	output logic [SEQ_W-1:0]  ack_seq
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [8:0] ENT_N = 9'(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef struct packed {
		logic [MAC_W-1:0]    mac;
		logic [SEQ_BITS-1:0] send;
		logic [SEQ_BITS-1:0] expd;
		logic [CRED_W-1:0]   credit;
	} entry_t;

	// table storage
	entry_t             mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;

	logic [CRED_W-1:0]   init_credit_q;
	logic [ACT_W-1:0]    act_q;
	logic [MAC_W-1:0]    mac_q;
	logic [SEQ_BITS-1:0] seq_q;
	logic [PIDX_W-1:0]   conn_q;

	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	entry_t           rd_data_s1;
	logic             rd_vld_s1;
	logic             scan_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	entry_t           rd_ent;

	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	entry_t           match_ent_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic             idx_bad;
	logic [IDX_W-1:0] conn_idx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic [STAT_W-1:0]   res_status_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [SEQ_BITS-1:0] res_send_q;
	logic [CRED_W-1:0]   res_cred_q;
	logic [SEQ_BITS-1:0] res_ack_q;
	logic [STAT_W-1:0]   res_status_d;
	logic [IDX_W-1:0]    res_idx_d;
	logic [SEQ_BITS-1:0] res_send_d;
	logic [CRED_W-1:0]   res_cred_d;
	logic [SEQ_BITS-1:0] res_ack_d;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			init_credit_q <= CREDIT_RESET;
		else if (cfg_wr_en)
			init_credit_q <= cfg_wr_data;
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q  <= action;
			mac_q  <= mac_addr;
			seq_q  <= SEQ_BITS'(seq_num);
			conn_q <= conn_index;
		end
	end

	assign idx_bad  = (9'(conn_q) >= ENT_N);
	assign conn_idx = IDX_W'(conn_q);

	// status towards the controller
	always_comb begin
		sts           = '0;
		sts.is_scan   = (act_q == ACT_LOOKUP) || (act_q == ACT_OPEN);
		sts.is_err    = ((act_q == ACT_OPEN) && (seq_q != '0)) ||
			((act_q == ACT_DELETE || act_q == ACT_RESPOND) && idx_bad);
		sts.scan_last = (cnt_q == LAST_IDX);
	end

	// scan address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.load_in)
			cnt_q <= '0;
		else if (cmd.scan_rd && (cnt_q != LAST_IDX))
			cnt_q <= cnt_q + 1'b1;
	end

	assign rd_en   = cmd.scan_rd || cmd.idx_rd;
	assign rd_addr = cmd.scan_rd ? cnt_q : conn_idx;

	// memory read port, registered
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
		if (rd_en)
			rd_idx_s1 <= rd_addr;
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// entry valid bits and read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			scan_s1   <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_s1 <= vld_q[rd_addr];
			scan_s1 <= cmd.scan_rd;
		end
	end

	// an entry never written reads as cleared
	assign rd_ent = rd_vld_s1 ? rd_data_s1 : '0;

	// first match and first free entry seen in the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.load_in) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (scan_s1) begin
			if (!match_q && (mac_q != '0) && (rd_ent.mac == mac_q))
				match_q <= 1'b1;
			if (!free_q && (rd_ent.mac == '0))
				free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s1 && !match_q && (mac_q != '0) && (rd_ent.mac == mac_q)) begin
			match_idx_q <= rd_idx_s1;
			match_ent_q <= rd_ent;
		end
		if (scan_s1 && !free_q && (rd_ent.mac == '0))
			free_idx_q <= rd_idx_s1;
	end

	// action execution: table update and result
	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = conn_idx;
		wr_data      = rd_ent;
		res_status_d = STAT_OK;
		res_idx_d    = '0;
		res_send_d   = '0;
		res_cred_d   = '0;
		res_ack_d    = '0;
		if (sts.is_err) begin
			res_status_d = (act_q == ACT_OPEN) ? STAT_BADSEQ : STAT_NOTFOUND;
		end else begin
			unique case (act_q)
				ACT_LOOKUP: begin
					if (match_q) begin
						wr_en     = cmd.commit;
						wr_addr   = match_idx_q;
						wr_data   = match_ent_q;
						if (match_ent_q.expd <= seq_q)
							wr_data.expd = seq_q + 1'b1;
						res_idx_d = match_idx_q;
					end else begin
						res_status_d = STAT_NOTFOUND;
					end
				end
				ACT_OPEN: begin
					if (match_q || free_q) begin
						wr_en          = cmd.commit;
						wr_addr        = match_q ? match_idx_q : free_idx_q;
						wr_data.mac    = mac_q;
						wr_data.send   = '0;
						wr_data.expd   = SEQ_BITS'(1);
						wr_data.credit = init_credit_q;
						res_idx_d      = wr_addr;
					end else begin
						res_status_d = STAT_FULL;
					end
				end
				ACT_DELETE: begin
					wr_en       = cmd.commit;
					wr_data.mac = '0;
					res_idx_d   = conn_idx;
				end
				ACT_RESPOND: begin
					wr_en        = cmd.commit;
					wr_data.send = rd_ent.send + 1'b1;
					res_idx_d    = conn_idx;
					res_send_d   = rd_ent.send;
					res_cred_d   = rd_ent.credit;
					res_ack_d    = seq_q;
				end
				default: res_status_d = STAT_NOTFOUND;
			endcase
		end
	end

	// result held until the output slot frees
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status_q <= res_status_d;
			res_idx_q    <= res_idx_d;
			res_send_q   <= res_send_d;
			res_cred_q   <= res_cred_d;
			res_ack_q    <= res_ack_d;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status      <= res_status_q;
			entry_index <= PIDX_W'(res_idx_q);
			send_seq    <= SEQ_W'(res_send_q);
			credit_out  <= res_cred_q;
			ack_seq     <= SEQ_W'(res_ack_q);
		end
	end

endmodule

>>> rtl/link_connection_table.sv
`timescale 1ns / 1ps

// Connection table of ENTRIES peers keyed by MAC address; every request gives
// one response. Lookup and open walk the whole table through a single memory
// read port, one entry per cycle, before the response is offered; delete and
// respond read the addressed entry once; a request refused straight away
// (open with a nonzero sequence, index beyond the table) reads no entry.
// The next request can be accepted once a response is offered. One request
// is in progress at a time; a finished response waits in an output register
// while the next request is taken, and that request cannot hand over its own
// response until the register is free. The table reads as all free right
// after reset (per-entry valid bits, no clearing pass). The user must write
// initial_credit through cfg_wr_en / cfg_wr_data only while no request is in
// progress; the block itself does not enforce it.
module link_connection_table
	import lct_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int SEQ_BITS = SEQ_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CRED_W-1:0] cfg_wr_data,
	lct_req_if.sink           req,
	lct_rsp_if.source         rsp
);

	lct_cmd_t cmd;
	lct_sts_t sts;

	// sequencing
	lct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and result path
	lct_dp #(
		.ENTRIES  (ENTRIES),
		.SEQ_BITS (SEQ_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.action      (req.action),
		.mac_addr    (req.mac_addr),
		.seq_num     (req.seq_num),
		.conn_index  (req.conn_index),
		.cmd         (cmd),
		.sts         (sts),
		.status      (rsp.status),
		.entry_index (rsp.entry_index),
		.send_seq    (rsp.send_seq),
		.credit_out  (rsp.credit_out),
		.ack_seq     (rsp.ack_seq)
	);

endmodule

>>> verif/lct_reply_checker.sv
`timescale 1ns / 1ps

module lct_reply_checker
	import lct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CRED_W-1:0] cfg_wr_data,
	lct_req_if                req,
	lct_rsp_if                rsp,
	output int                pending,
	output int                mismatches
);

	localparam int N_ENTRIES = ENTRIES_DEF;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PIDX_W-1:0] entry_index;
		logic [SEQ_W-1:0]  send_seq;
		logic [CRED_W-1:0] credit_out;
		logic [SEQ_W-1:0]  ack_seq;
	} reply_t;

	// shadow copy of the connection table
	logic [MAC_W-1:0]  peer_mac    [N_ENTRIES];
	logic [SEQ_W-1:0]  send_ctr    [N_ENTRIES];
	logic [SEQ_W-1:0]  rx_expected [N_ENTRIES];
	logic [CRED_W-1:0] entry_credit[N_ENTRIES];
	logic [CRED_W-1:0] open_credit;
	reply_t            expected_replies[$];
	int                reply_no;

	initial mismatches = 0;

	task automatic note_failure(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// lowest live entry holding this mac; mac zero never matches
	function automatic int find_peer(input logic [MAC_W-1:0] mac);
		if (mac == '0)
			return -1;
		for (int i = 0; i < N_ENTRIES; i++)
			if (peer_mac[i] == mac)
				return i;
		return -1;
	endfunction

	// applies one table action to the shadow state and returns its reply
	function automatic reply_t apply_table_action(
		input logic [ACT_W-1:0]  act,
		input logic [MAC_W-1:0]  mac,
		input logic [SEQ_W-1:0]  seq,
		input logic [PIDX_W-1:0] idx
	);
		reply_t r;
		int     e;
		r = '0;
		case (act)
			ACT_LOOKUP: begin
				e = find_peer(mac);
				if (e < 0) begin
					r.status = STAT_NOTFOUND;
				end else begin
					// plain unsigned compare, the increment wraps
					if (rx_expected[e] <= seq)
						rx_expected[e] = seq + 1'b1;
					r.entry_index = e[PIDX_W-1:0];
				end
			end
			ACT_OPEN: begin
				if (seq != '0) begin
					r.status = STAT_BADSEQ;
				end else begin
					e = find_peer(mac);
					if (e < 0) begin
						// claim the lowest free entry
						for (int i = N_ENTRIES - 1; i >= 0; i--)
							if (peer_mac[i] == '0)
								e = i;
						if (e >= 0)
							peer_mac[e] = mac;
					end
					if (e < 0) begin
						r.status = STAT_FULL;
					end else begin
						send_ctr[e]     = '0;
						rx_expected[e]  = SEQ_W'(1);
						entry_credit[e] = open_credit;
						r.entry_index   = e[PIDX_W-1:0];
					end
				end
			end
			default: begin
				if (int'(idx) >= N_ENTRIES) begin
					r.status = STAT_NOTFOUND;
				end else if (act == ACT_DELETE) begin
					peer_mac[idx] = '0;
					r.entry_index = idx;
				end else begin
					r.credit_out  = entry_credit[idx];
					r.ack_seq     = seq;
					r.send_seq    = send_ctr[idx];
					send_ctr[idx] = send_ctr[idx] + 1'b1;
					r.entry_index = idx;
				end
			end
		endcase
		return r;
	endfunction

	// watch both channels, predict on each request and compare on each reply
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < N_ENTRIES; i++) begin
				peer_mac[i]     = '0;
				send_ctr[i]     = '0;
				rx_expected[i]  = '0;
				entry_credit[i] = '0;
			end
			open_credit = CREDIT_RESET;
			expected_replies.delete();
			reply_no = 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				open_credit = cfg_wr_data;

			// reply transaction
			if (rsp.valid && rsp.ready) begin
				reply_no++;
				if (expected_replies.size() == 0) begin
					note_failure($sformatf("reply %0d arrived with nothing outstanding",
						reply_no));
				end else begin
					want = expected_replies.pop_front();
					if (rsp.status !== want.status)
						note_failure($sformatf("reply %0d status %0d, predicted %0d",
							reply_no, rsp.status, want.status));
					if (rsp.entry_index !== want.entry_index)
						note_failure($sformatf("reply %0d entry_index %0d, predicted %0d",
							reply_no, rsp.entry_index, want.entry_index));
					if (rsp.send_seq !== want.send_seq)
						note_failure($sformatf("reply %0d send_seq %0h, predicted %0h",
							reply_no, rsp.send_seq, want.send_seq));
					if (rsp.credit_out !== want.credit_out)
						note_failure($sformatf("reply %0d credit_out %0d, predicted %0d",
							reply_no, rsp.credit_out, want.credit_out));
					if (rsp.ack_seq !== want.ack_seq)
						note_failure($sformatf("reply %0d ack_seq %0h, predicted %0h",
							reply_no, rsp.ack_seq, want.ack_seq));
				end
			end

			// request transaction
			if (req.valid && req.ready)
				expected_replies.push_back(apply_table_action(req.action, req.mac_addr,
					req.seq_num, req.conn_index));

			pending <= expected_replies.size();
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lct_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int POOL_SIZE   = 20;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 155;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CRED_W-1:0] cfg_wr_data;
	logic              sink_ready = 1'b0;
	int                pending;
	int                mismatches;
	int                cycle_count = 0;
	int                burst_left = 0;
	bit                steady_sender = 1'b0;
	int                rdy_mode = 0;
	int                rdy_left = 0;
	logic [MAC_W-1:0]  peer_pool[POOL_SIZE];

	lct_req_if req_ch();
	lct_rsp_if rsp_ch();

	assign rsp_ch.ready = sink_ready;

	link_connection_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	lct_reply_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.pending     (pending),
		.mismatches  (mismatches)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// reply side: free flow, random stalls or mostly stalled, switched now and then
	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode <= $urandom_range(0, 2);
			rdy_left <= $urandom_range(50, 400);
		end else begin
			rdy_left <= rdy_left - 1;
		end
		case (rdy_mode)
			0:       sink_ready <= 1'b1;
			1:       sink_ready <= 1'($urandom_range(0, 1));
			default: sink_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// one request transaction, sent in bursts with random gaps between them
	task automatic push_request(
		input logic [ACT_W-1:0]  act,
		input logic [MAC_W-1:0]  mac,
		input logic [SEQ_W-1:0]  seq,
		input logic [PIDX_W-1:0] idx
	);
		int gap;
		if (burst_left == 0) begin
			if (steady_sender)
				gap = 0;
			else if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(10, 30);
			else
				gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.mac_addr   <= mac;
		req_ch.seq_num    <= seq;
		req_ch.conn_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// stop sending and wait for every outstanding reply
	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly well-formed traffic over a small set of peers, some noise
	task automatic issue_random_item();
		int                pick;
		logic [ACT_W-1:0]  act;
		logic [MAC_W-1:0]  mac;
		logic [SEQ_W-1:0]  seq;
		pick = $urandom_range(0, 99);
		mac = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
		if ($urandom_range(0, 15) == 0)
			mac = $urandom_range(0, 1) ? '0 : MAC_W'({$urandom(), $urandom()});
		case ($urandom_range(0, 3))
			0:       seq = SEQ_W'($urandom_range(0, 40));
			1:       seq = SEQ_W'($urandom());
			2:       seq = {SEQ_W{1'b1}} - SEQ_W'($urandom_range(0, 2));
			default: seq = '0;
		endcase
		if (pick < 30) begin
			act = ACT_LOOKUP;
		end else if (pick < 55) begin
			act = ACT_OPEN;
			if ($urandom_range(0, 7) != 0)
				seq = '0;
		end else if (pick < 70) begin
			act = ACT_DELETE;
		end else begin
			act = ACT_RESPOND;
		end
		push_request(act, mac, seq, PIDX_W'($urandom_range(0, 15)));
	endtask

	initial begin
		logic [CRED_W-1:0] credit;

		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.action     <= ACT_LOOKUP;
		req_ch.mac_addr   <= '0;
		req_ch.seq_num    <= '0;
		req_ch.conn_index <= '0;

		peer_pool[0] = {MAC_W{1'b1}};
		peer_pool[1] = MAC_W'(1);
		for (int i = 2; i < POOL_SIZE; i++)
			peer_pool[i] = MAC_W'({$urandom(), $urandom()});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero mac, bad open sequence, wrap of the expected sequence,
		// free entries, delete then lookup, table full and reuse
		push_request(ACT_LOOKUP, '0, '0, '0);
		push_request(ACT_OPEN, peer_pool[0], '0, '0);
		push_request(ACT_OPEN, peer_pool[2], {SEQ_W{1'b1}}, '0);
		push_request(ACT_OPEN, '0, '0, '0);
		push_request(ACT_LOOKUP, peer_pool[0], {SEQ_W{1'b1}}, '0);
		push_request(ACT_LOOKUP, peer_pool[0], '0, '0);
		push_request(ACT_RESPOND, '0, {SEQ_W{1'b1}}, '0);
		push_request(ACT_RESPOND, '0, '0, {PIDX_W{1'b1}});
		push_request(ACT_DELETE, '0, '0, {PIDX_W{1'b1}});
		push_request(ACT_DELETE, '0, '0, '0);
		push_request(ACT_LOOKUP, peer_pool[0], '0, '0);
		for (int i = 1; i <= 17; i++)
			push_request(ACT_OPEN, peer_pool[i], '0, '0);
		push_request(ACT_OPEN, peer_pool[1], '0, '0);

		// random phases, each under its own open credit
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0, 5:    credit = {CRED_W{1'b1}};
				1:       credit = '0;
				default: credit = CRED_W'($urandom_range(0, 31));
			endcase
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= credit;
			@(posedge clk);
			cfg_wr_en   <= 1'b0;
			steady_sender = ($urandom_range(0, 2) == 0);
			repeat (PHASE_ITEMS) issue_random_item();
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
